@@ sv/prsm_pkg.sv @@
// Package: shared transaction types, mode and status codes, sizing defaults.
package prsm_pkg;

    localparam int DEF_MAX_PAGES   = 256;
    localparam int DEF_SLOTS       = 64;
    localparam int DEF_RECORD_BITS = 64;
    localparam logic [6:0] SPP_RESET = 7'd64;

    localparam logic [2:0] MODE_INSERT     = 3'd0;
    localparam logic [2:0] MODE_DELETE     = 3'd1;
    localparam logic [2:0] MODE_GET        = 3'd2;
    localparam logic [2:0] MODE_UPDATE     = 3'd3;
    localparam logic [2:0] MODE_SCAN_FIRST = 3'd4;
    localparam logic [2:0] MODE_SCAN_NEXT  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [8:0]  page_number;
        logic [5:0]  slot_number;
        logic [63:0] record_word;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  result_page;
        logic [5:0]  result_slot;
        logic [63:0] read_word;
    } t_rsp;

endpackage

@@ sv/prsm_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module prsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/paged_record_slot_manager_core.sv @@
// Top level: paged record slot manager over a bitmap RAM and a record RAM.
// Delete, update and get read the addressed page from the bitmap RAM, and get then reads
// the record RAM; insert and scan walk pages read from the bitmap RAM; result goes to an
// output register. One transaction is worked at a time; the next is taken once the result
// is queued. Reset is synchronous: after it the bitmap RAM is cleared one page per cycle
// with input stalled; the record RAM is not cleared.
module paged_record_slot_manager_core #(
    parameter int MAX_PAGES   = prsm_pkg::DEF_MAX_PAGES,
    parameter int SLOTS       = prsm_pkg::DEF_SLOTS,
    parameter int RECORD_BITS = prsm_pkg::DEF_RECORD_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [6:0]     i_cfg_data,
    input  logic           i_in_valid,
    input  prsm_pkg::t_req i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output prsm_pkg::t_rsp o_out_data,
    input  logic           i_out_stall
);
    import prsm_pkg::*;

    localparam int PI_W  = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
    localparam int PG_W  = $clog2(MAX_PAGES + 2);
    localparam int SW    = $clog2(SLOTS);
    localparam int RDEP  = MAX_PAGES * SLOTS;
    localparam int RA_W  = RDEP > 1 ? $clog2(RDEP) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SRCH, S_SEVAL, S_AEVAL, S_RISS, S_RDAT, S_PUSH
    } t_state;

    t_state                 r_state;
    logic [PI_W-1:0]        r_clr;
    logic [6:0]             r_spp;
    logic [PG_W-1:0]        r_hi;
    logic [PG_W-1:0]        r_cur_pg;
    logic [5:0]             r_cur_sl;
    logic [2:0]             r_op;
    logic [PG_W-1:0]        r_pg;
    logic [5:0]             r_sl;
    logic [6:0]             r_start;
    logic [RECORD_BITS-1:0] r_word;
    t_rsp                   r_res;
    t_rsp                   r_out;
    logic                   r_ov;

    logic [6:0]             eff;
    logic [SLOTS-1:0]       um;
    logic [SLOTS-1:0]       sm;
    logic [SLOTS-1:0]       bm_rdata;
    logic [SLOTS-1:0]       cand;
    logic [SLOTS-1:0]       oh;
    logic                   hit;
    logic [5:0]             enc;
    logic [5:0]             n_slot;
    logic                   addr_op;
    logic                   past_hi;
    logic                   can_new;
    logic                   cur_bit;
    logic                   bm_we;
    logic [PI_W-1:0]        bm_waddr;
    logic [SLOTS-1:0]       bm_wdata;
    logic                   rec_we;
    logic [RA_W-1:0]        rec_waddr;
    logic [RA_W-1:0]        rec_raddr;
    logic [RECORD_BITS-1:0] rec_rdata;
    logic [PI_W-1:0]        pidx;
    logic                   in_ok;

    assign eff = (r_spp > 7'(SLOTS)) ? 7'(SLOTS) : r_spp;
    assign pidx = PI_W'(r_pg - PG_W'(1));

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            um[i] = 7'(i) < eff;
            sm[i] = 7'(i) >= r_start;
        end
    end

    assign cand = (r_op == MODE_INSERT) ? (~bm_rdata & um) : (bm_rdata & um & sm);
    assign hit  = |cand;

    always_comb begin
        enc = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                enc = 6'(i);
            end
        end
    end

    assign addr_op = (r_op == MODE_DELETE) || (r_op == MODE_GET) || (r_op == MODE_UPDATE);
    assign past_hi = r_pg > r_hi;
    assign can_new = (32'(r_pg) <= MAX_PAGES) && (eff != 7'd0);
    assign cur_bit = bm_rdata[SW'(r_sl)];

    always_comb begin
        unique case (r_state)
            S_SEVAL: n_slot = enc;
            S_SRCH:  n_slot = 6'd0;
            default: n_slot = r_sl;
        endcase
    end

    assign oh = {{(SLOTS - 1){1'b0}}, 1'b1} << SW'(n_slot);

    always_comb begin
        bm_we    = 1'b0;
        bm_wdata = '0;
        rec_we   = 1'b0;
        unique case (r_state)
            S_CLEAR: bm_we = 1'b1;
            S_SRCH: begin
                if (!addr_op && r_op == MODE_INSERT && past_hi && can_new) begin
                    bm_we    = 1'b1;
                    bm_wdata = oh;
                    rec_we   = 1'b1;
                end
            end
            S_SEVAL: begin
                if (r_op == MODE_INSERT && hit) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata | oh;
                    rec_we   = 1'b1;
                end
            end
            S_AEVAL: begin
                if (cur_bit && r_op == MODE_DELETE) begin
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata & ~oh;
                end
                if (cur_bit && r_op == MODE_UPDATE) begin
                    rec_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign bm_waddr  = (r_state == S_CLEAR) ? r_clr : pidx;
    assign rec_waddr = RA_W'(pidx) * RA_W'(SLOTS) + RA_W'(n_slot);
    assign rec_raddr = RA_W'(pidx) * RA_W'(SLOTS) + RA_W'(r_sl);

    prsm_ram #(.WIDTH(SLOTS), .DEPTH(MAX_PAGES)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (pidx),
        .o_rdata (bm_rdata)
    );

    prsm_ram #(.WIDTH(RECORD_BITS), .DEPTH(RDEP)) u_records (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (r_word),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    assign in_ok = (i_in_data.page_number != 9'd0) && (32'(i_in_data.page_number) <= MAX_PAGES)
                   && ({1'b0, i_in_data.slot_number} < eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_spp    <= SPP_RESET;
            r_hi     <= PG_W'(1);
            r_cur_pg <= PG_W'(1);
            r_cur_sl <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spp <= i_cfg_data;
            end
            if (r_ov && !i_out_stall && r_state != S_PUSH) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + PI_W'(1);
                    if (r_clr == PI_W'(MAX_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.mode;
                        r_word  <= RECORD_BITS'(i_in_data.record_word);
                        r_res   <= '{status: (i_in_data.mode == MODE_SCAN_NEXT
                                              && r_cur_pg > r_hi) ? ST_END : ST_EMPTY,
                                     result_page: '0, result_slot: '0, read_word: '0};
                        priority case (i_in_data.mode)
                            MODE_INSERT: begin
                                r_pg    <= PG_W'(1);
                                r_state <= S_SRCH;
                            end
                            MODE_DELETE, MODE_GET, MODE_UPDATE: begin
                                if (in_ok) begin
                                    r_pg    <= PG_W'(i_in_data.page_number);
                                    r_sl    <= i_in_data.slot_number;
                                    r_state <= S_SRCH;
                                end else begin
                                    r_state <= S_PUSH;
                                end
                            end
                            MODE_SCAN_FIRST: begin
                                r_pg    <= PG_W'(1);
                                r_start <= '0;
                                r_state <= S_SRCH;
                            end
                            MODE_SCAN_NEXT: begin
                                if (r_cur_pg > r_hi) begin
                                    r_state <= S_PUSH;
                                end else begin
                                    r_pg    <= r_cur_pg;
                                    r_start <= {1'b0, r_cur_sl} + 7'd1;
                                    r_state <= S_SRCH;
                                end
                            end
                            default: r_state <= S_PUSH;
                        endcase
                    end
                end
                S_SRCH: begin
                    if (addr_op) begin
                        r_state <= S_AEVAL;
                    end else if (past_hi) begin
                        r_state <= S_PUSH;
                        if (r_op == MODE_INSERT) begin
                            if (can_new) begin
                                r_hi     <= r_pg;
                                r_cur_pg <= r_pg;
                                r_cur_sl <= '0;
                                r_res    <= '{status: ST_OK, result_page: 9'(r_pg),
                                              result_slot: '0, read_word: '0};
                            end else begin
                                r_res <= '{status: ST_FULL, result_page: '0,
                                           result_slot: '0, read_word: '0};
                            end
                        end else begin
                            r_cur_pg <= r_pg;
                            r_cur_sl <= '0;
                            r_res    <= '{status: ST_END, result_page: '0,
                                          result_slot: '0, read_word: '0};
                        end
                    end else begin
                        r_state <= S_SEVAL;
                    end
                end
                S_SEVAL: begin
                    if (hit) begin
                        r_cur_pg <= r_pg;
                        r_cur_sl <= enc;
                        r_sl     <= enc;
                        if (r_op == MODE_INSERT) begin
                            r_res   <= '{status: ST_OK, result_page: 9'(r_pg),
                                         result_slot: enc, read_word: '0};
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_RISS;
                        end
                    end else begin
                        r_pg    <= r_pg + PG_W'(1);
                        r_start <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_AEVAL: begin
                    if (cur_bit) begin
                        r_cur_pg <= r_pg;
                        r_cur_sl <= r_sl;
                        if (r_op == MODE_GET) begin
                            r_state <= S_RISS;
                        end else begin
                            r_res   <= '{status: ST_OK, result_page: 9'(r_pg),
                                         result_slot: r_sl, read_word: '0};
                            r_state <= S_PUSH;
                        end
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_RISS: r_state <= S_RDAT;
                S_RDAT: begin
                    r_res   <= '{status: ST_OK, result_page: 9'(r_pg), result_slot: r_sl,
                                 read_word: 64'(rec_rdata)};
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out   <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_hi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hi >= PG_W'(1)) && (32'(r_hi) <= MAX_PAGES))
        else $error("high-water page out of range");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_pg <= r_hi + PG_W'(1))
        else $error("cursor beyond high-water page plus one");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result during bitmap clear");
endmodule

@@ tb/testbench.sv @@
// Testbench for the paged record slot manager: directed and random transactions checked against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import prsm_pkg::*;

    localparam int NPAGES = 256;
    localparam int NSLOTS = 64;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [6:0] i_cfg_data;
    logic i_in_valid;
    t_req i_in_data;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;
    logic i_out_stall;

    paged_record_slot_manager_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );

    // predictor state
    logic [63:0] page_bits [NPAGES];
    logic [63:0] rec_mem [NPAGES*NSLOTS];
    int unsigned top_page;
    int unsigned cur_page;
    int unsigned cur_slot;
    logic [6:0]  spp;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int errors;
    int sent;
    int checked;
    int snd_idle_pct;
    int rcv_idle_pct;
    longint cycles;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_slots();
        return (spp > NSLOTS) ? NSLOTS : int'(spp);
    endfunction

    function automatic logic [63:0] usable();
        int unsigned n;
        n = eff_slots();
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic bit is_occ(int unsigned pg, int unsigned sl);
        if (pg < 1 || pg > NPAGES || sl >= eff_slots()) return 0;
        return page_bits[pg-1][sl];
    endfunction

    function automatic t_rsp mk(logic [1:0] st, int unsigned pg, int unsigned sl,
                                logic [63:0] w);
        t_rsp r;
        r.status = st;
        r.result_page = pg[8:0];
        r.result_slot = sl[5:0];
        r.read_word = w;
        return r;
    endfunction

    function automatic t_rsp walk_occupied(int unsigned pg, int unsigned sl);
        int unsigned n;
        n = eff_slots();
        while (pg <= top_page) begin
            if (sl >= n) begin
                pg++;
                sl = 0;
            end else if (is_occ(pg, sl)) begin
                cur_page = pg;
                cur_slot = sl;
                return mk(ST_OK, pg, sl, rec_mem[(pg-1)*NSLOTS+sl]);
            end else begin
                sl++;
            end
        end
        cur_page = pg;
        cur_slot = 0;
        return mk(ST_END, 0, 0, 0);
    endfunction

    function automatic t_rsp predict_slot_op(t_req q);
        logic [63:0] freeb;
        int unsigned pg;
        int unsigned sl;
        int unsigned idx;
        pg = q.page_number;
        sl = q.slot_number;
        case (q.mode)
            MODE_INSERT: begin
                for (int p = 1; p <= NPAGES; p++) begin
                    freeb = ~page_bits[p-1] & usable();
                    if (freeb != 0) begin
                        int s;
                        s = 0;
                        while (!freeb[s]) s++;
                        page_bits[p-1][s] = 1'b1;
                        rec_mem[(p-1)*NSLOTS+s] = q.record_word;
                        if (p > top_page) top_page = p;
                        cur_page = p;
                        cur_slot = s;
                        return mk(ST_OK, p, s, 0);
                    end
                end
                return mk(ST_FULL, 0, 0, 0);
            end
            MODE_DELETE, MODE_GET, MODE_UPDATE: begin
                if (!is_occ(pg, sl)) return mk(ST_EMPTY, 0, 0, 0);
                idx = (pg-1)*NSLOTS + sl;
                cur_page = pg;
                cur_slot = sl;
                if (q.mode == MODE_DELETE) begin
                    page_bits[pg-1][sl] = 1'b0;
                    return mk(ST_OK, pg, sl, 0);
                end else if (q.mode == MODE_GET) begin
                    return mk(ST_OK, pg, sl, rec_mem[idx]);
                end
                rec_mem[idx] = q.record_word;
                return mk(ST_OK, pg, sl, 0);
            end
            MODE_SCAN_FIRST: return walk_occupied(1, 0);
            MODE_SCAN_NEXT: begin
                if (cur_page > top_page) return mk(ST_END, 0, 0, 0);
                return walk_occupied(cur_page, cur_slot + 1);
            end
            default: return mk(ST_EMPTY, 0, 0, 0);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_rsps.push_back(predict_slot_op(i_in_data));
                sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    i_in_data <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp exp_r;
        cycles++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    checked++;
                    if (o_out_data.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 o_out_data.status);
                        errors++;
                    end
                    if (o_out_data.result_page !== exp_r.result_page) begin
                        $display("%0t: page exp %0d got %0d", $time, exp_r.result_page,
                                 o_out_data.result_page);
                        errors++;
                    end
                    if (o_out_data.result_slot !== exp_r.result_slot) begin
                        $display("%0t: slot exp %0d got %0d", $time, exp_r.result_slot,
                                 o_out_data.result_slot);
                        errors++;
                    end
                    if (o_out_data.read_word !== exp_r.read_word) begin
                        $display("%0t: word exp %h got %h", $time, exp_r.read_word,
                                 o_out_data.read_word);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_req req(logic [2:0] m, logic [8:0] pg, logic [5:0] sl,
                                 logic [63:0] w);
        t_req q;
        q.mode = m;
        q.page_number = pg;
        q.slot_number = sl;
        q.record_word = w;
        return q;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // target page 1 to the top page plus one (at least 3) and a slot below the slot limit, or any address
    function automatic t_req rand_addr_req(logic [2:0] m);
        int unsigned pg;
        int unsigned sl;
        if ($urandom_range(9) < 7) begin
            pg = $urandom_range(top_page < 3 ? 3 : top_page + 1, 1);
            sl = $urandom_range(eff_slots() == 0 ? 0 : eff_slots() - 1);
        end else begin
            pg = $urandom_range(511);
            sl = $urandom_range(63);
        end
        return req(m, 9'(pg), 6'(sl), rand_word());
    endfunction

    task automatic drain(int extra);
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_spp(logic [6:0] v);
        drain(NPAGES * 2 + 20);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        spp = v;
    endtask

    // random mix; reads never land on a never-written cell since bits mark writes
    task automatic run_random(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 40) pending_reqs.push_back(req(MODE_INSERT, 9'($urandom), 6'($urandom),
                                                   rand_word()));
            else if (k < 55) pending_reqs.push_back(rand_addr_req(MODE_DELETE));
            else if (k < 68) pending_reqs.push_back(rand_addr_req(MODE_GET));
            else if (k < 78) pending_reqs.push_back(rand_addr_req(MODE_UPDATE));
            else if (k < 82) pending_reqs.push_back(req(MODE_SCAN_FIRST, 9'($urandom),
                                                        6'($urandom), 0));
            else if (k < 97) pending_reqs.push_back(req(MODE_SCAN_NEXT, 9'($urandom),
                                                        6'($urandom), 0));
            else pending_reqs.push_back(req(3'($urandom_range(7, 6)), 9'($urandom),
                                            6'($urandom), rand_word()));
            if (pending_reqs.size() > 16) begin
                while (pending_reqs.size() > 4) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        errors = 0;
        sent = 0;
        checked = 0;
        cycles = 0;
        snd_idle_pct = 18;
        rcv_idle_pct = 78;
        spp = SPP_RESET;
        top_page = 1;
        cur_page = 1;
        cur_slot = 0;
        for (int p = 0; p < NPAGES; p++) page_bits[p] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        pending_reqs.push_back(req(MODE_SCAN_FIRST, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SCAN_NEXT, 0, 0, 0));
        pending_reqs.push_back(req(MODE_GET, 1, 0, 0));
        pending_reqs.push_back(req(MODE_INSERT, 0, 0, '1));
        pending_reqs.push_back(req(MODE_INSERT, 9'h1FF, 6'h3F, 64'h0));
        pending_reqs.push_back(req(MODE_INSERT, 0, 0, 64'h8000_0000_0000_0001));
        pending_reqs.push_back(req(MODE_GET, 1, 0, 0));
        pending_reqs.push_back(req(MODE_UPDATE, 1, 1, 64'h5555_AAAA_5555_AAAA));
        pending_reqs.push_back(req(MODE_GET, 1, 1, 0));
        pending_reqs.push_back(req(MODE_DELETE, 1, 0, 0));
        pending_reqs.push_back(req(MODE_DELETE, 1, 0, 0));
        pending_reqs.push_back(req(MODE_GET, 0, 0, 0));
        pending_reqs.push_back(req(MODE_GET, 257, 1, 0));
        pending_reqs.push_back(req(MODE_UPDATE, 9'h1FF, 6'h3F, '1));
        pending_reqs.push_back(req(MODE_SCAN_FIRST, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SCAN_NEXT, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SCAN_NEXT, 0, 0, 0));
        pending_reqs.push_back(req(MODE_SCAN_NEXT, 0, 0, 0));
        pending_reqs.push_back(req(3'd6, 1, 1, 0));
        pending_reqs.push_back(req(3'd7, 1, 1, 0));
        pending_reqs.push_back(req(MODE_INSERT, 0, 0, 64'h1234));

        // zero slots: every page full, and out-of-range addressing
        write_spp(7'd0);
        pending_reqs.push_back(req(MODE_INSERT, 0, 0, 1));
        pending_reqs.push_back(req(MODE_GET, 1, 1, 0));
        pending_reqs.push_back(req(MODE_SCAN_FIRST, 0, 0, 0));

        // one slot per page: the 258 inserts fill the store
        write_spp(7'd1);
        for (int i = 0; i < 258; i++)
            pending_reqs.push_back(req(MODE_INSERT, 0, 0, {$urandom, $urandom}));
        pending_reqs.push_back(req(MODE_GET, 256, 0, 0));
        pending_reqs.push_back(req(MODE_DELETE, 256, 0, 0));
        pending_reqs.push_back(req(MODE_INSERT, 0, 0, 64'hFEED));
        run_random(100);

        write_spp(7'd127);
        run_random(250);

        snd_idle_pct = 78;
        rcv_idle_pct = 18;
        write_spp(7'd5);
        run_random(200);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_spp(7'd64);
        run_random(200);
        write_spp(7'd33);
        run_random(115);

        drain(NPAGES * 2 + 20);
        $display("Sent %0d transactions, checked %0d results", sent, checked);
        $display("Slot limits 0, 1, 5, 33, 64 and 127, including a full store");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/prsm_pkg.sv
sv/prsm_ram.sv
sv/paged_record_slot_manager_core.sv
tb/testbench.sv
